// ===== hw/rtl/rimwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rimwm_pkg
// Shared types and constants of the idle residency window monitor.
// ----------------------------------------------------------------------------
package rimwm_pkg;

  localparam int TICK_W      = 48;
  localparam int CNT_W       = 32;
  localparam int REG_W       = 24;
  localparam int NUM_WAKE    = 5;
  localparam int NUM_LANES   = 3 + NUM_WAKE;
  localparam int QUO_W       = 64;
  localparam int MS_W        = 10;
  localparam int RATE_W      = 16;

  localparam int RING_DEPTH_DEF       = 16;
  localparam int TICKS_PER_SECOND_DEF = 1024;

  localparam logic [REG_W-1:0] MIN_SPACING_RST = 24'd4096;
  localparam logic [REG_W-1:0] WINDOW_RST      = 24'd61440;

  localparam logic [MS_W-1:0]   MS_FULL  = 10'd1000;
  localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

  typedef enum logic {
    REG_MIN_SPACING = 1'b0,
    REG_WINDOW      = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [TICK_W-1:0]               wall;
    logic [TICK_W-1:0]               deep_sleep;
    logic [TICK_W-1:0]               deep_wfi;
    logic [TICK_W-1:0]               light_wfi;
    logic [NUM_WAKE-1:0][CNT_W-1:0]  wakes;
  } slot_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GAP  = 7'b0000010,
    S_WRD  = 7'b0000100,
    S_WCK  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

// ===== hw/rtl/idle_residency_window_monitor_top.sv =====
// ----------------------------------------------------------------------------
// idle_residency_window_monitor_top
// Windowed idle residency and wake rate monitor over a ring of snapshots.
// ----------------------------------------------------------------------------
// Usage:
//   A snapshot transfer happens at a clock edge with start high and busy low.
//   The block folds it into the newest ring slot or advances the ring, walks
//   from the newest slot toward older ones to find the anchor, then divides
//   the eight differences by the span in eight bit-serial dividers.
//   One result appears for exactly one cycle with done high; the receiver
//   cannot stall, so results are simply presented and taken.
//   The walk covers 1 to RING_DEPTH-1 older slots, each through a read step
//   and a check step (S_WRD, S_WCK), and the dividers then produce their 64
//   quotient bits. One sample at a time; no new start is taken while busy.
//   With fewer than two slots the walk and division are skipped; with a zero
//   span only the division is. Both report running_ms = 1000, all else zero.
//   Registers: wr_en, wr_index, wr_data write min_spacing_ticks (0) and
//   window_ticks (1); user must write only while idle, block does not check.
//   Reset (synchronous rst) empties the ring and restores register defaults;
//   ring RAM contents are not cleared, fill count marks what is valid.
// ----------------------------------------------------------------------------
module idle_residency_window_monitor_top #(
  parameter int RING_DEPTH       = rimwm_pkg::RING_DEPTH_DEF,
  parameter int TICKS_PER_SECOND = rimwm_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [rimwm_pkg::REG_W-1:0]   wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [rimwm_pkg::TICK_W-1:0]  wall_count,
  input  logic [rimwm_pkg::TICK_W-1:0]  deep_sleep_total,
  input  logic [rimwm_pkg::TICK_W-1:0]  deep_wfi_total,
  input  logic [rimwm_pkg::TICK_W-1:0]  light_wfi_total,
  input  logic [rimwm_pkg::CNT_W-1:0]   wakes_all,
  input  logic [rimwm_pkg::CNT_W-1:0]   wakes_by_timer,
  input  logic [rimwm_pkg::CNT_W-1:0]   wakes_by_pin,
  input  logic [rimwm_pkg::CNT_W-1:0]   wakes_by_radio,
  input  logic [rimwm_pkg::CNT_W-1:0]   wakes_unclassified,
  output logic                          done,
  output logic [rimwm_pkg::MS_W-1:0]    deep_sleep_ms,
  output logic [rimwm_pkg::MS_W-1:0]    deep_wfi_ms,
  output logic [rimwm_pkg::MS_W-1:0]    light_wfi_ms,
  output logic [rimwm_pkg::MS_W-1:0]    running_ms,
  output logic [rimwm_pkg::RATE_W-1:0]  rate_all,
  output logic [rimwm_pkg::RATE_W-1:0]  rate_timer,
  output logic [rimwm_pkg::RATE_W-1:0]  rate_pin,
  output logic [rimwm_pkg::RATE_W-1:0]  rate_radio,
  output logic [rimwm_pkg::RATE_W-1:0]  rate_other
);

  localparam int IW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW     = $clog2(RING_DEPTH + 1);
  localparam int TW     = rimwm_pkg::TICK_W;
  localparam int CW     = rimwm_pkg::CNT_W;
  localparam int QW     = rimwm_pkg::QUO_W;
  localparam int NW     = rimwm_pkg::NUM_WAKE;
  localparam int NL     = rimwm_pkg::NUM_LANES;
  localparam int RATE_K = 60 * TICKS_PER_SECOND;

  rimwm_pkg::state_t state;
  rimwm_pkg::slot_t  cur;       // incoming snapshot, becomes the newest slot
  rimwm_pkg::slot_t  rd_slot;
  rimwm_pkg::slot_t  anc;

  logic [rimwm_pkg::REG_W-1:0] min_spacing;
  logic [rimwm_pkg::REG_W-1:0] window;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [FW-1:0] filled;
  logic [FW-1:0] filled_next;
  logic [IW-1:0] ptr;
  logic [FW-1:0] cnt;
  logic          zero_res;

  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [TW-1:0] gap;
  logic [TW-1:0] age;
  logic [TW-1:0] span;
  logic [TW-1:0] span_r;

  logic [NL-1:0][QW-1:0] num_r;
  logic [NL-1:0][QW-1:0] quo;
  logic [NL-1:0]         lane_done;
  logic                  div_go;

  assign busy = (state != rimwm_pkg::S_IDLE);

  // Ring RAM holds one whole snapshot per slot.
  rimwm_ram #(
    .WIDTH ($bits(rimwm_pkg::slot_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_next),
    .wdata (cur),
    .raddr (ram_raddr),
    .rdata (rd_slot)
  );

  // Newest slot is read at transfer; walk reads older slots only, which
  // never collide with the slot being written.
  assign ram_raddr = (state == rimwm_pkg::S_WRD) ? ptr : head;
  assign ram_we    = (state == rimwm_pkg::S_GAP);

  assign gap  = TW'(cur.wall - rd_slot.wall);
  assign age  = TW'(cur.wall - rd_slot.wall);
  assign span = TW'(cur.wall - anc.wall);

  // Slot choice for the incoming snapshot.
  always_comb begin
    head_next   = head;
    filled_next = filled;
    if (filled == '0) begin
      head_next   = '0;
      filled_next = FW'(1);
    end else if (gap >= TW'(min_spacing)) begin
      head_next = (head == IW'(RING_DEPTH - 1)) ? '0 : IW'(head + 1'b1);
      if (filled != FW'(RING_DEPTH)) begin
        filled_next = FW'(filled + 1'b1);
      end
    end
  end

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing <= rimwm_pkg::MIN_SPACING_RST;
      window      <= rimwm_pkg::WINDOW_RST;
    end else if (wr_en) begin
      case (wr_index)
        rimwm_pkg::REG_MIN_SPACING: min_spacing <= wr_data;
        rimwm_pkg::REG_WINDOW:      window      <= wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rimwm_pkg::S_IDLE;
      head   <= '0;
      filled <= '0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        rimwm_pkg::S_IDLE: begin
          if (start) begin
            state <= rimwm_pkg::S_GAP;
          end
        end
        rimwm_pkg::S_GAP: begin
          head   <= head_next;
          filled <= filled_next;
          if (filled_next < FW'(2)) begin
            state <= rimwm_pkg::S_OUT;
          end else begin
            state <= rimwm_pkg::S_WRD;
          end
        end
        rimwm_pkg::S_WRD: begin
          state <= rimwm_pkg::S_WCK;
        end
        rimwm_pkg::S_WCK: begin
          if (age >= TW'(window) || cnt == FW'(filled - 1'b1)) begin
            state <= rimwm_pkg::S_MUL;
          end else begin
            state <= rimwm_pkg::S_WRD;
          end
        end
        rimwm_pkg::S_MUL: begin
          if (span == '0) begin
            state <= rimwm_pkg::S_OUT;
          end else begin
            div_go <= 1'b1;
            state  <= rimwm_pkg::S_DIV;
          end
        end
        rimwm_pkg::S_DIV: begin
          if (lane_done[0]) begin
            state <= rimwm_pkg::S_OUT;
          end
        end
        rimwm_pkg::S_OUT: begin
          state <= rimwm_pkg::S_IDLE;
        end
        default: state <= rimwm_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rimwm_pkg::S_IDLE: begin
        cur.wall       <= wall_count;
        cur.deep_sleep <= deep_sleep_total;
        cur.deep_wfi   <= deep_wfi_total;
        cur.light_wfi  <= light_wfi_total;
        cur.wakes[0]   <= wakes_all;
        cur.wakes[1]   <= wakes_by_timer;
        cur.wakes[2]   <= wakes_by_pin;
        cur.wakes[3]   <= wakes_by_radio;
        cur.wakes[4]   <= wakes_unclassified;
      end
      rimwm_pkg::S_GAP: begin
        zero_res <= (filled_next < FW'(2));
        ptr      <= (head_next == '0) ? IW'(RING_DEPTH - 1) : IW'(head_next - 1'b1);
        cnt      <= FW'(1);
      end
      rimwm_pkg::S_WCK: begin
        anc <= rd_slot;
        ptr <= (ptr == '0) ? IW'(RING_DEPTH - 1) : IW'(ptr - 1'b1);
        cnt <= FW'(cnt + 1'b1);
      end
      rimwm_pkg::S_MUL: begin
        zero_res <= (span == '0);
        span_r   <= span;
        num_r[0] <= QW'(TW'(cur.deep_sleep - anc.deep_sleep)) * QW'(1000);
        num_r[1] <= QW'(TW'(cur.deep_wfi - anc.deep_wfi)) * QW'(1000);
        num_r[2] <= QW'(TW'(cur.light_wfi - anc.light_wfi)) * QW'(1000);
        for (int k = 0; k < NW; k++) begin
          num_r[3+k] <= QW'(CW'(cur.wakes[k] - anc.wakes[k])) * QW'(RATE_K);
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    rimwm_div #(
      .NUM_W (QW),
      .DEN_W (TW)
    ) u_div (
      .clk  (clk),
      .rst  (rst),
      .go   (div_go),
      .num  (num_r[g]),
      .den  (span_r),
      .done (lane_done[g]),
      .quo  (quo[g])
    );
  end

  // Clamp chain: each idle figure saturates at what the earlier ones leave.
  logic [rimwm_pkg::MS_W-1:0] ds_c, dw_c, lw_c, dw_s, lw_s, left1, left2;

  always_comb begin
    ds_c  = (quo[0] > QW'(rimwm_pkg::MS_FULL)) ? rimwm_pkg::MS_FULL : quo[0][rimwm_pkg::MS_W-1:0];
    dw_s  = (quo[1] > QW'(rimwm_pkg::MS_FULL)) ? rimwm_pkg::MS_FULL : quo[1][rimwm_pkg::MS_W-1:0];
    lw_s  = (quo[2] > QW'(rimwm_pkg::MS_FULL)) ? rimwm_pkg::MS_FULL : quo[2][rimwm_pkg::MS_W-1:0];
    left1 = rimwm_pkg::MS_FULL - ds_c;
    dw_c  = (dw_s > left1) ? left1 : dw_s;
    left2 = left1 - dw_c;
    lw_c  = (lw_s > left2) ? left2 : lw_s;
  end

  logic [NW-1:0][rimwm_pkg::RATE_W-1:0] rate_c;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      rate_c[k] = (quo[3+k] > QW'(rimwm_pkg::RATE_MAX)) ? rimwm_pkg::RATE_MAX
                                                       : quo[3+k][rimwm_pkg::RATE_W-1:0];
    end
  end

  // Result register, one cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == rimwm_pkg::S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == rimwm_pkg::S_OUT) begin
      if (zero_res) begin
        deep_sleep_ms <= '0;
        deep_wfi_ms   <= '0;
        light_wfi_ms  <= '0;
        running_ms    <= rimwm_pkg::MS_FULL;
        rate_all      <= '0;
        rate_timer    <= '0;
        rate_pin      <= '0;
        rate_radio    <= '0;
        rate_other    <= '0;
      end else begin
        deep_sleep_ms <= ds_c;
        deep_wfi_ms   <= dw_c;
        light_wfi_ms  <= lw_c;
        running_ms    <= left2 - lw_c;
        rate_all      <= rate_c[0];
        rate_timer    <= rate_c[1];
        rate_pin      <= rate_c[2];
        rate_radio    <= rate_c[3];
        rate_other    <= rate_c[4];
      end
    end
  end

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer taken but block not busy");

  a_done_source : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == rimwm_pkg::S_OUT)
    else $error("result strobe without output step");

  a_sum_full : assert property (@(posedge clk) disable iff (rst)
    done |-> (12'(deep_sleep_ms) + 12'(deep_wfi_ms) + 12'(light_wfi_ms)
              + 12'(running_ms)) == 12'(rimwm_pkg::MS_FULL))
    else $error("residency figures do not sum to full second");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    filled <= FW'(RING_DEPTH))
    else $error("fill count beyond ring depth");

endmodule

// ===== hw/rtl/rimwm_ram.sv =====
// ----------------------------------------------------------------------------
// rimwm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rimwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rimwm_div.sv =====
// ----------------------------------------------------------------------------
// rimwm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rimwm_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= num;
    end else if (run) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule
